### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh : concurrent assertion helpers
// Clocked on clk; the plain form is gated by rst, the reset form is not.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property outside reset
`define SMPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property that must also hold through reset
`define SMPC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/smpc_pkg.sv
// ----------------------------------------------------------------------------
// smpc_pkg : shared constants and types
// Time constants, reciprocals for the countdown split and stage bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package smpc_pkg;

  localparam logic [31:0] SECONDS_PER_DAY   = 32'd86400;
  localparam int          PIPE_DEPTH        = 7;

  // rounding thresholds of the arc: span times 1, 3, 5, 7, 9, 11
  localparam int          NUM_ODD           = 6;

  // hours: (rem >> 4) / 225, reciprocal floor(2^32 / 225)
  localparam logic [24:0] HOUR_RECIP        = 25'd19088743;
  localparam logic [8:0]  HOUR_ODD          = 9'd225;
  // minutes: y / 15 for y < 900, reciprocal ceil(2^16 / 15)
  localparam logic [12:0] MIN_RECIP         = 13'd4370;

  localparam logic [3:0]  DAY_BASE_SPRITE   = 4'd7;
  localparam logic [3:0]  NIGHT_BASE_SPRITE = 4'd14;
  localparam logic [3:0]  NO_DATA_SPRITE    = 4'd7;

  // span, elapsed and countdown of one beat
  typedef struct packed {
    logic        has_data;
    logic        night;
    logic [31:0] span;
    logic [31:0] elapsed;
    logic [31:0] remaining;
  } win_t;

  // sprite and flags at the output stage
  typedef struct packed {
    logic        has_data;
    logic        night;
    logic [3:0]  sprite;
  } arc_out_t;

  // countdown split at the output stage
  typedef struct packed {
    logic [31:0] seconds;
    logic [20:0] hours;
    logic [5:0]  minutes;
  } hms_out_t;

endpackage

`default_nettype wire

### rtl/sun_moon_phase_countdown.sv
// ----------------------------------------------------------------------------
// sun_moon_phase_countdown : sun/moon sprite and countdown to next event
// Pipeline: each accepted input beat passes through seven registered stages.
// Throughput: one beat per cycle; all seven stages advance together and
// hold while the output beat waits.
// Reset: rst (synchronous) empties the pipeline; payload is not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sun_moon_phase_countdown (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] now_seconds,
  input  wire logic [31:0] sunrise_seconds,
  input  wire logic [31:0] sunset_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             has_data,
  output logic [3:0]       sprite_index,
  output logic             target_is_sunrise,
  output logic [31:0]      remaining_seconds,
  output logic [20:0]      remaining_hours,
  output logic [5:0]       remaining_minutes
);
  import smpc_pkg::*;

  logic                  advance;
  logic [PIPE_DEPTH-1:0] vld;
  win_t                  win;
  arc_out_t              arc;
  hms_out_t              hms;

  logic [32:0]           split_lo;
  logic [32:0]           split_hi;
  logic                  blank_ok;
  logic                  side_ok;
  logic                  split_ok;

  // advance whenever the last stage is empty or being drained
  assign advance  = !vld[PIPE_DEPTH-1] || out_ready;
  assign in_ready = advance;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  smpc_window u_window (
    .clk             (clk),
    .en              (advance),
    .now_seconds     (now_seconds),
    .sunrise_seconds (sunrise_seconds),
    .sunset_seconds  (sunset_seconds),
    .win             (win)
  );

  smpc_arc u_arc (
    .clk (clk),
    .en  (advance),
    .win (win),
    .arc (arc)
  );

  smpc_hms u_hms (
    .clk       (clk),
    .en        (advance),
    .remaining (win.remaining),
    .hms       (hms)
  );

  // drive the output beat
  assign out_valid         = vld[PIPE_DEPTH-1];
  assign has_data          = arc.has_data;
  assign sprite_index      = arc.sprite;
  assign target_is_sunrise = arc.night;
  assign remaining_seconds = hms.seconds;
  assign remaining_hours   = hms.hours;
  assign remaining_minutes = hms.minutes;

  // rebuild the countdown from its split and classify the sprite
  assign split_lo = {12'b0, remaining_hours} * 33'd3600
                  + {27'b0, remaining_minutes} * 33'd60;
  assign split_hi = split_lo + 33'd60;
  assign blank_ok = (sprite_index == NO_DATA_SPRITE) && (remaining_seconds == 32'd0)
                  && !target_is_sunrise;
  assign side_ok  = target_is_sunrise ? (sprite_index inside {[4'd8:NIGHT_BASE_SPRITE]})
                                      : (sprite_index inside {[4'd1:DAY_BASE_SPRITE]});
  assign split_ok = (remaining_minutes < 6'd60) && (split_lo <= {1'b0, remaining_seconds})
                  && (split_hi > {1'b0, remaining_seconds});

  // checks
  `SMPC_ASSERT(a_no_data_blank, (out_valid && !has_data) |-> blank_ok, "no-data beat not blanked")
  `SMPC_ASSERT(a_sprite_side, (out_valid && has_data) |-> side_ok, "sprite on wrong side")
  `SMPC_ASSERT(a_hms_split, out_valid |-> split_ok, "countdown split inconsistent")
  `SMPC_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "pipeline not empty after reset")

endmodule

`default_nettype wire

### rtl/smpc_window.sv
// ----------------------------------------------------------------------------
// smpc_window : day/night window, stages 1 and 2
// Picks the span ends, then forms span, elapsed time and countdown.
// ----------------------------------------------------------------------------
`default_nettype none

module smpc_window (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [31:0]          now_seconds,
  input  wire logic [31:0]          sunrise_seconds,
  input  wire logic [31:0]          sunset_seconds,
  output smpc_pkg::win_t            win
);
  import smpc_pkg::*;

  logic        hd_c;
  logic        before_c;
  logic        night_c;
  logic [31:0] start_c;
  logic [31:0] end_c;

  logic        s1_hd;
  logic        s1_night;
  logic [31:0] s1_start;
  logic [31:0] s1_end;
  logic [31:0] s1_now;

  win_t        win_c;

  // classify the beat and choose the window ends
  always_comb begin
    hd_c     = (sunrise_seconds != 32'd0) && (sunset_seconds != 32'd0);
    before_c = now_seconds < sunrise_seconds;
    night_c  = before_c || (now_seconds >= sunset_seconds);
    if (!night_c) begin
      start_c = sunrise_seconds;
      end_c   = sunset_seconds;
    end else if (before_c) begin
      start_c = sunset_seconds - SECONDS_PER_DAY;
      end_c   = sunrise_seconds;
    end else begin
      start_c = sunset_seconds;
      end_c   = sunrise_seconds + SECONDS_PER_DAY;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hd    <= hd_c;
      s1_night <= night_c && hd_c;
      s1_start <= start_c;
      s1_end   <= end_c;
      s1_now   <= now_seconds;
    end
  end

  // span, elapsed and countdown; the target is always the window end
  always_comb begin
    win_c.has_data  = s1_hd;
    win_c.night     = s1_night;
    win_c.span      = (s1_end > s1_start) ? (s1_end - s1_start) : 32'd1;
    win_c.elapsed   = (s1_now > s1_start) ? (s1_now - s1_start) : 32'd0;
    win_c.remaining = (s1_hd && (s1_end > s1_now)) ? (s1_end - s1_now) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      win <= win_c;
    end
  end

endmodule

`default_nettype wire

### rtl/smpc_arc.sv
// ----------------------------------------------------------------------------
// smpc_arc : arc height to sprite, stages 3 to 7
// Clamps elapsed time, forms the height numerator, compares it against
// the odd multiples of the span and counts the step.
// ----------------------------------------------------------------------------
`default_nettype none

module smpc_arc (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire smpc_pkg::win_t       win,
  output smpc_pkg::arc_out_t        arc
);
  import smpc_pkg::*;

  logic [1:0]  f3, f4, f5, f6;          // {has_data, night}
  logic [31:0] a3_span, a3_el;
  logic [31:0] a4_span, a4_h;
  logic [35:0] a5_m12;
  logic [35:0] a5_odd [NUM_ODD];
  logic [2:0]  a6_step;

  logic [32:0] twice_c;
  logic [32:0] h_c;
  logic [35:0] h_w;
  logic [35:0] sp_w;
  logic [2:0]  step_c;
  arc_out_t    arc_c;

  // stage 3: clamp elapsed to span
  always_ff @(posedge clk) begin
    if (en) begin
      f3      <= {win.has_data, win.night};
      a3_span <= win.span;
      a3_el   <= (win.elapsed > win.span) ? win.span : win.elapsed;
    end
  end

  // stage 4: height numerator span - |2*el - span|
  always_comb begin
    twice_c = {a3_el, 1'b0};
    if (twice_c >= {1'b0, a3_span}) begin
      h_c = {a3_span, 1'b0} - twice_c;
    end else begin
      h_c = twice_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4      <= f3;
      a4_span <= a3_span;
      a4_h    <= h_c[31:0];
    end
  end

  // stage 5: 12*h and span times 1, 3, 5, 7, 9, 11
  always_comb begin
    h_w  = {4'b0, a4_h};
    sp_w = {4'b0, a4_span};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f5        <= f4;
      a5_m12    <= (h_w << 3) + (h_w << 2);
      a5_odd[0] <= sp_w;
      a5_odd[1] <= (sp_w << 1) + sp_w;
      a5_odd[2] <= (sp_w << 2) + sp_w;
      a5_odd[3] <= (sp_w << 3) - sp_w;
      a5_odd[4] <= (sp_w << 3) + sp_w;
      a5_odd[5] <= (sp_w << 3) + (sp_w << 1) + sp_w;
    end
  end

  // stage 6: step counts the rounding thresholds reached
  always_comb begin
    step_c = 3'd0;
    for (int k = 0; k < NUM_ODD; k++) begin
      step_c = step_c + {2'b0, (a5_m12 >= a5_odd[k])};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f6      <= f5;
      a6_step <= step_c;
    end
  end

  // stage 7: map step to sun or moon sprite
  always_comb begin
    arc_c.has_data = f6[1];
    arc_c.night    = f6[0];
    if (!f6[1]) begin
      arc_c.sprite = NO_DATA_SPRITE;
    end else if (f6[0]) begin
      arc_c.sprite = NIGHT_BASE_SPRITE - {1'b0, a6_step};
    end else begin
      arc_c.sprite = DAY_BASE_SPRITE - {1'b0, a6_step};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      arc <= arc_c;
    end
  end

endmodule

`default_nettype wire

### rtl/smpc_hms.sv
// ----------------------------------------------------------------------------
// smpc_hms : countdown split into hours and minutes, stages 3 to 7
// Divides by 3600 through a reciprocal multiply with one correction step,
// then divides the leftover by 60 through a small reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module smpc_hms (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [31:0]          remaining,
  output smpc_pkg::hms_out_t        hms
);
  import smpc_pkg::*;

  logic [31:0] h3_rem, h4_rem, h5_rem, h6_rem;
  logic [52:0] h3_prod;
  logic [27:0] h3_r1, h4_r1;
  logic [3:0]  h3_low, h4_low, h5_low;
  logic [20:0] h4_q, h5_q, h6_q;
  logic [8:0]  h5_r;
  logic [9:0]  h6_y;

  logic [27:0] q_w;
  logic [27:0] qm_c;
  logic [27:0] diff_c;
  logic [7:0]  rc_c;
  logic [20:0] qc_c;
  logic [22:0] mprod_c;
  hms_out_t    hms_c;

  // stage 3: multiply the sixteenths by the reciprocal of 225
  always_ff @(posedge clk) begin
    if (en) begin
      h3_rem  <= remaining;
      h3_r1   <= remaining[31:4];
      h3_low  <= remaining[3:0];
      h3_prod <= {25'b0, remaining[31:4]} * {28'b0, HOUR_RECIP};
    end
  end

  // stage 4: take the estimate, at most one short
  always_ff @(posedge clk) begin
    if (en) begin
      h4_rem <= h3_rem;
      h4_r1  <= h3_r1;
      h4_low <= h3_low;
      h4_q   <= h3_prod[52:32];
    end
  end

  // stage 5: partial remainder r1 - 225*q
  always_comb begin
    q_w    = {7'b0, h4_q};
    qm_c   = (q_w << 8) - (q_w << 5) + q_w;
    diff_c = h4_r1 - qm_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h5_rem <= h4_rem;
      h5_low <= h4_low;
      h5_q   <= h4_q;
      h5_r   <= diff_c[8:0];
    end
  end

  // stage 6: correct the quotient, form (rem % 3600) / 4
  always_comb begin
    if (h5_r >= HOUR_ODD) begin
      qc_c = h5_q + 21'd1;
      rc_c = 8'(h5_r - HOUR_ODD);
    end else begin
      qc_c = h5_q;
      rc_c = h5_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h6_rem <= h5_rem;
      h6_q   <= qc_c;
      h6_y   <= {rc_c, h5_low[3:2]};
    end
  end

  // stage 7: minutes = y / 15
  always_comb begin
    mprod_c       = {13'b0, h6_y} * {10'b0, MIN_RECIP};
    hms_c.seconds = h6_rem;
    hms_c.hours   = h6_q;
    hms_c.minutes = mprod_c[21:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hms <= hms_c;
    end
  end

endmodule

`default_nettype wire
